// File: rtl/sha_pkg.sv
package sha_pkg;
    localparam int unsigned BUF_DEPTH = 64;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned FIFO_DEPTH = 4;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       eom;
    } t_item;

    localparam t_word IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word K [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
    };

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (WORD_W - n));
    endfunction
endpackage

// File: rtl/sha_fifo.sv
module sha_fifo #(
    parameter int unsigned DEPTH = sha_pkg::FIFO_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sha_pkg::t_item i_item,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output sha_pkg::t_item o_item
);
    import sha_pkg::*;
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_item          r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_mem[r_wp] <= i_item;
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop && !o_empty)
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push && !o_full) - (AW+1)'(i_pop && !o_empty);
        end
    end
endmodule

// File: rtl/sha_core.sv
module sha_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  sha_pkg::t_item i_item,
    output logic           o_pop,
    output logic [31:0]    o_digest_word,
    output logic [2:0]     o_word_index,
    output logic           o_last_word,
    output logic           o_empty,
    input  logic           i_pop
);
    import sha_pkg::*;

    typedef enum logic [2:0] {
        S_TAKE, S_ROUND, S_FIN, S_PAD, S_OUT
    } t_state;

    t_state      r_state;
    t_word       r_h [8];
    t_word       r_v [8];
    t_word       r_w [16];   // block words, reused as the schedule window
    logic [5:0]  r_fill;
    logic [5:0]  r_rnd;
    logic [63:0] r_bits;
    logic        r_final;    // compression belongs to the closing pass
    logic        r_lenblk;   // next pad block is the length-only block
    logic        r_pend_end; // end seen with the byte that filled the block
    logic [2:0]  r_oidx;

    t_word w_cur, t1, t2, e, a, s0, s1, w_new;

    always_comb begin
        w_cur = r_w[0];
        e = r_v[4];
        a = r_v[0];
        t1 = r_v[7] + (rotr(e,6) ^ rotr(e,11) ^ rotr(e,25)) + ((e & r_v[5]) ^ (~e & r_v[6]))
             + K[r_rnd] + w_cur;
        t2 = (rotr(a,2) ^ rotr(a,13) ^ rotr(a,22)) + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));
        s0 = rotr(r_w[1],7) ^ rotr(r_w[1],18) ^ (r_w[1] >> 3);
        s1 = rotr(r_w[14],17) ^ rotr(r_w[14],19) ^ (r_w[14] >> 10);
        w_new = s1 + r_w[9] + s0 + r_w[0];
    end

    assign o_pop         = (r_state == S_TAKE) && !i_empty;
    assign o_empty       = (r_state != S_OUT);
    assign o_digest_word = r_h[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 3'd7);

    // pad fill: write 0x80 at r_fill, zero above, length if room
    task automatic do_pad(input logic with_marker, input logic [5:0] pos, input logic put_len);
        for (int b = 0; b < 64; b++) begin
            // length bytes are written as whole words below
            if (b < 56 || !put_len) begin
                if (b[5:0] > pos || (b[5:0] == pos && !with_marker))
                    r_w[b[5:2]][8*(3-b[1:0]) +: 8] <= 8'h00;
                else if (b[5:0] == pos)
                    r_w[b[5:2]][8*(3-b[1:0]) +: 8] <= 8'h80;
            end
        end
        if (put_len) begin
            r_w[14] <= r_bits[63:32];
            r_w[15] <= r_bits[31:0];
        end
    endtask

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_TAKE;
            for (int i = 0; i < 8; i++) r_h[i] <= IV[i];
            r_fill <= '0;
            r_bits <= '0;
            r_final <= 1'b0;
            r_lenblk <= 1'b0;
            r_pend_end <= 1'b0;
            r_oidx <= '0;
            r_rnd <= '0;
        end else begin
            unique case (r_state)
                S_TAKE: if (!i_empty) begin
                    if (i_item.present) begin
                        r_w[r_fill[5:2]][8*(3-r_fill[1:0]) +: 8] <= i_item.data;
                        r_bits <= r_bits + 64'd8;
                        r_fill <= r_fill + 6'd1;
                        if (r_fill == 6'd63) begin
                            r_pend_end <= i_item.eom;
                            r_final <= 1'b0;
                            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                            r_rnd <= '0;
                            r_state <= S_ROUND;
                        end else if (i_item.eom) begin
                            r_state <= S_PAD;
                        end
                    end else if (i_item.eom) begin
                        r_state <= S_PAD;
                    end
                end
                S_PAD: begin
                    // r_fill is bytes held; r_lenblk for the second block
                    if (r_lenblk) begin
                        for (int i = 0; i < 14; i++) r_w[i] <= '0;
                        r_w[14] <= r_bits[63:32];
                        r_w[15] <= r_bits[31:0];
                        r_final <= 1'b1;
                        r_lenblk <= 1'b0;
                    end else if (r_fill < 6'd56) begin
                        do_pad(1'b1, r_fill, 1'b1);
                        r_final <= 1'b1;
                    end else begin
                        do_pad(1'b1, r_fill, 1'b0);
                        r_final <= 1'b0;
                        r_lenblk <= 1'b1;
                    end
                    r_fill <= '0;
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    r_rnd <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= w_new;
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) r_state <= S_FIN;
                end
                S_FIN: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_oidx <= '0;
                    if (r_final) r_state <= S_OUT;
                    else if (r_lenblk || r_pend_end) begin
                        r_pend_end <= 1'b0;
                        r_state <= S_PAD;
                    end else r_state <= S_TAKE;
                end
                S_OUT: if (i_pop) begin
                    r_oidx <= r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        for (int i = 0; i < 8; i++) r_h[i] <= IV[i];
                        r_bits <= '0;
                        r_fill <= '0;
                        r_final <= 1'b0;
                        r_state <= S_TAKE;
                    end
                end
                default: r_state <= S_TAKE;
            endcase
        end
    end
endmodule

// File: rtl/sha256_hash_engine_core.sv
// each padding block is loaded in S_PAD, compressed round by round in S_ROUND, then folded in S_FIN
// a message end adds one or two such blocks, then eight digest words, one per pop
// intake: about one byte per cycle while the queue holds items, paused while a full block compresses
// the item queue (four deep by default) keeps accepting while the back end compresses, until it is full
// reset: synchronous active-low i_rst_n restores initial hash, clears count and queue
module sha256_hash_engine_core #(
    parameter int unsigned FIFO_DEPTH = sha_pkg::FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sha_pkg::*;

    t_item q_in, q_out;
    logic  q_empty, q_pop;

    assign q_in = '{data: i_data_byte, present: i_byte_present, eom: i_end_of_message};

    // front end: item queue, each transaction lands here
    sha_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk, .i_rst_n, .i_push(push), .i_item(q_in), .o_full(full),
        .i_pop(q_pop), .o_empty(q_empty), .o_item(q_out)
    );

    // back end: buffering, padding, compression and digest readout
    sha_core u_core (
        .i_clk, .i_rst_n, .i_empty(q_empty), .i_item(q_out), .o_pop(q_pop),
        .o_digest_word, .o_word_index, .o_last_word, .o_empty(empty), .i_pop(pop)
    );
endmodule

// File: rtl/sha_checker.sv
module sha_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic [2:0] o_word_index,
    input logic       o_last_word
);
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_last_word == (o_word_index == 3'd7))) else $error("last flag");
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last_word) |=> (!empty && o_word_index == $past(o_word_index) + 3'd1))
        else $error("index step");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty) else $error("result dropped");
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_last_word) |=> empty) else $error("extra word");
endmodule

bind sha256_hash_engine_core sha_checker u_chk (
    .i_clk, .i_rst_n, .empty, .pop, .o_word_index, .o_last_word
);

// File: verif/testbench.sv
module testbench;
    import sha_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       present;
        logic       eom;
    } t_stim;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_byte_present = 1'b0;
    logic        i_end_of_message = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    sha256_hash_engine_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_data_byte     (i_data_byte),
        .i_byte_present  (i_byte_present),
        .i_end_of_message(i_end_of_message),
        .empty           (empty),
        .pop             (pop),
        .o_digest_word   (o_digest_word),
        .o_word_index    (o_word_index),
        .o_last_word     (o_last_word)
    );

    always #6 i_clk = ~i_clk;

    // stimulus waiting for the driver, and digest words waiting for the monitor
    t_stim        pending_items[$];
    t_digest_word digest_fifo[$];

    // idle rates in percent, set per phase
    int unsigned send_idle_pct = 10;
    int unsigned recv_idle_pct = 82;
    int unsigned hold_requests = 0;

    int unsigned mismatches = 0;
    int unsigned words_checked = 0;
    int unsigned messages_hashed = 0;
    int unsigned bytes_hashed = 0;
    int unsigned items_accepted = 0;

    // predictor state: chaining value, block buffer, fill index and bit length
    logic [31:0] hash_state[8];
    logic [7:0]  block_bytes[64];
    int unsigned block_fill;
    logic [63:0] length_bits;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic start_message();
        for (int i = 0; i < 8; i++) hash_state[i] = IV[i];
        block_fill = 0;
        length_bits = '0;
    endtask

    // one 64-round compression of block_bytes into hash_state
    task automatic compress();
        logic [31:0] w[64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        {a, b, c, d, e, f, g, h} = {hash_state[0], hash_state[1], hash_state[2], hash_state[3],
                                    hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
        for (int i = 0; i < 64; i++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
                 + K[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endtask

    // absorb one accepted transaction; on end of message pad and queue the digest
    task automatic hash_item(input t_stim it);
        t_digest_word dw;
        if (it.present) begin
            block_bytes[block_fill] = it.data;
            length_bits += 64'd8;
            block_fill++;
            bytes_hashed++;
            if (block_fill == 64) begin
                compress();
                block_fill = 0;
            end
        end
        if (it.eom) begin
            block_bytes[block_fill] = 8'h80;
            block_fill++;
            // no room for the length: close this block and pad a fresh one
            if (block_fill > 56) begin
                for (int i = block_fill; i < 64; i++) block_bytes[i] = 8'h00;
                compress();
                block_fill = 0;
            end
            for (int i = block_fill; i < 56; i++) block_bytes[i] = 8'h00;
            for (int i = 0; i < 8; i++) block_bytes[56+i] = length_bits[63-8*i -: 8];
            compress();
            for (int i = 0; i < 8; i++) begin
                dw.word = hash_state[i];
                dw.index = 3'(i);
                dw.last = (i == 7);
                digest_fifo.insert(digest_fifo.size(), dw);
            end
            messages_hashed++;
            start_message();
        end
    endtask

    // driver: one transaction offered at a time, held until accepted
    always @(posedge i_clk) begin
        t_stim nxt;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                nxt.data = i_data_byte;
                nxt.present = i_byte_present;
                nxt.eom = i_end_of_message;
                hash_item(nxt);
                items_accepted++;
            end
            if (!push || !full) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_items.pop_front();
                    i_data_byte <= nxt.data;
                    i_byte_present <= nxt.present;
                    i_end_of_message <= nxt.eom;
                    push <= 1'b1;
                end else begin
                    push <= 1'b0;
                    i_data_byte <= 8'($urandom);
                end
            end
        end
    end

    // monitor: check each popped digest word, and stall pop at random or for a long hold
    int unsigned hold_left = 0;
    int unsigned holds_seen = 0;
    always @(posedge i_clk) begin
        t_digest_word exp_w;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (digest_fifo.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected digest word %h index %0d", o_digest_word,
                                 o_word_index);
                end else begin
                    exp_w = digest_fifo.pop_front();
                    words_checked++;
                    if (o_digest_word !== exp_w.word || o_word_index !== exp_w.index ||
                        o_last_word !== exp_w.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("digest mismatch: expected %h/%0d/%0d got %h/%0d/%0d",
                                     exp_w.word, exp_w.index, exp_w.last,
                                     o_digest_word, o_word_index, o_last_word);
                    end
                end
            end
            if (holds_seen != hold_requests) begin
                holds_seen <= hold_requests;
                hold_left <= 600;
                pop <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic add_item(input logic [7:0] d, input logic p, input logic e);
        t_stim it;
        it.data = d;
        it.present = p;
        it.eom = e;
        pending_items.insert(pending_items.size(), it);
    endtask

    // message of n bytes; the end rides on the last byte or on a separate empty item
    task automatic add_message(input int unsigned n, input bit separate_end);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(15) == 0) add_item(8'($urandom), 1'b0, 1'b0);
            add_item(8'($urandom), 1'b1, (i == n - 1) && !separate_end);
        end
        if (separate_end || n == 0) add_item(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic random_messages(input int unsigned item_budget);
        int unsigned start_items;
        int unsigned n;
        start_items = items_accepted + pending_items.size();
        while (items_accepted + pending_items.size() - start_items < item_budget) begin
            case ($urandom_range(5))
                0: n = $urandom_range(54, 57);
                1: n = $urandom_range(62, 65);
                2: n = $urandom_range(118, 121);
                default: n = $urandom_range(0, 20);
            endcase
            add_message(n, $urandom_range(2) == 0);
        end
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && !push && digest_fifo.size() == 0);
        @(posedge i_clk);
    endtask

    initial begin
        start_message();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty message, "abc", byte extremes, idle items, separate end
        add_item(8'h5a, 1'b0, 1'b1);
        add_item(8'h61, 1'b1, 1'b0);
        add_item(8'h62, 1'b1, 1'b0);
        add_item(8'h63, 1'b1, 1'b1);
        add_item(8'hff, 1'b1, 1'b1);
        add_item(8'h00, 1'b1, 1'b1);
        add_item(8'hff, 1'b0, 1'b0);
        add_item(8'h00, 1'b1, 1'b0);
        add_item(8'h00, 1'b0, 1'b0);
        add_item(8'hff, 1'b1, 1'b0);
        add_item(8'haa, 1'b0, 1'b1);
        add_item(8'h55, 1'b1, 1'b0);
        add_item(8'h33, 1'b0, 1'b1);
        drain();

        // sender mostly busy, receiver mostly stalled
        random_messages(100);
        drain();

        send_idle_pct = 82;
        recv_idle_pct = 10;
        random_messages(80);
        drain();

        // full rate with a long receiver hold so the input side backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_message(130, 1'b0);
        hold_requests++;
        for (int i = 0; i < 4; i++) add_message(0, 1'b1);
        random_messages(10);
        drain();

        repeat (300) @(posedge i_clk);
        $display("hashed %0d messages (%0d bytes) from %0d transactions", messages_hashed,
                 bytes_hashed, items_accepted);
        $display("checked %0d digest words across three idle mixes and a long output hold",
                 words_checked);
        if (mismatches == 0 && digest_fifo.size() == 0) begin
            $display("** sha256_hash_engine_core: PASSED **");
        end else begin
            $display("** sha256_hash_engine_core: FAILED **");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(12 * 3000000);
        $display("timeout waiting for the engine");
        $display("** sha256_hash_engine_core: FAILED **");
        $finish;
    end
endmodule
